>>> rtl/spbe_pkg.sv
// Shared types, round constants and round functions of the reduced PRIDE-style cipher.
`timescale 1ns / 1ps
`default_nettype none

package spbe_pkg;

    // Number of rounds: ROUNDS-1 full rounds, then a last round with whitening.
    localparam int ROUNDS     = 9;
    localparam int TABLE_ROWS = 10;
    localparam int ROW_W      = 16;
    localparam int NUM_ROWS   = 4;
    localparam int RC_IDX_W   = $clog2(TABLE_ROWS);
    localparam int CFG_IDX_W  = 2;

    typedef logic [ROW_W-1:0]                row_t;
    typedef logic [NUM_ROWS-1:0][ROW_W-1:0]  block_t;
    typedef logic [RC_IDX_W-1:0]             rc_idx_t;
    typedef logic [CFG_IDX_W-1:0]            cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t KEY_ROW0_IDX = 2'd0;
    localparam cfg_idx_t KEY_ROW1_IDX = 2'd1;
    localparam cfg_idx_t KEY_ROW2_IDX = 2'd2;
    localparam cfg_idx_t KEY_ROW3_IDX = 2'd3;

    // Round constant rows; the first row and every row from nine upwards are zero.
    function automatic block_t round_const(input rc_idx_t idx);
        block_t rc;
        unique case (idx)
            4'd1:    rc = {16'h1319, 16'h8a2e, 16'h0370, 16'h7344};
            4'd2:    rc = {16'ha409, 16'h3822, 16'h299f, 16'h31d0};
            4'd3:    rc = {16'h082e, 16'hfa98, 16'hec4e, 16'h6c89};
            4'd4:    rc = {16'h4528, 16'h21e6, 16'h38d0, 16'h1377};
            4'd5:    rc = {16'hbe54, 16'h66cf, 16'h34e9, 16'h0c6c};
            4'd6:    rc = {16'h7ef8, 16'h4f78, 16'hfd95, 16'h5cb1};
            4'd7:    rc = {16'h8584, 16'h0851, 16'hf1ac, 16'h43aa};
            4'd8:    rc = {16'hc882, 16'hd32f, 16'h2532, 16'h3c54};
            default: rc = '0;
        endcase
        return rc;
    endfunction

    // Bitsliced 4-bit S-box; each column of the four rows is one S-box input.
    function automatic block_t sbox_layer(input block_t s);
        row_t a;
        row_t b;
        row_t c;
        row_t d;
        a = s[2] ^ (s[0] & s[1]);
        b = s[3] ^ (s[1] & s[2]);
        c = s[0] ^ (a & b);
        d = s[1] ^ (b & c);
        return {d, c, b, a};
    endfunction

    function automatic row_t mix_row0(input row_t x);
        return {x[11:0], x[15:12]} ^ {x[7:0], x[15:8]} ^ {x[3:0], x[15:4]};
    endfunction

    function automatic row_t mix_row1(input row_t x);
        logic [7:0] h;
        logic [7:0] l;
        logic [7:0] a;
        logic [7:0] b;
        h = x[15:8];
        l = x[7:0];
        a = h ^ {h[6:0], h[7]} ^ {l[4:0], l[7:5]};
        b = h ^ {l[4:0], l[7:5]} ^ {l[3:0], l[7:4]};
        return {a, b};
    endfunction

    function automatic row_t mix_row2(input row_t x);
        logic [7:0] h;
        logic [7:0] l;
        logic [7:0] a;
        logic [7:0] b;
        h = x[15:8];
        l = x[7:0];
        a = {h[3:0], h[7:4]} ^ {h[2:0], h[7:3]} ^ {l[0], l[7:1]};
        b = {h[3:0], h[7:4]} ^ l ^ {l[0], l[7:1]};
        return {a, b};
    endfunction

    function automatic row_t mix_row3(input row_t x);
        return x ^ {x[11:0], x[15:12]} ^ {x[3:0], x[15:4]};
    endfunction

    function automatic block_t linear_layer(input block_t s);
        return {mix_row3(s[3]), mix_row2(s[2]), mix_row1(s[1]), mix_row0(s[0])};
    endfunction

endpackage

`default_nettype wire

>>> rtl/spbe_round_cell.sv
// One full cipher round as a pipeline cell: key add, S-box and linear layer.
`timescale 1ns / 1ps
`default_nettype none

module spbe_round_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire spbe_pkg::block_t up_state,
    input  wire spbe_pkg::block_t stage_key,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output spbe_pkg::block_t     dn_state
);

    logic             valid_reg;
    logic             valid_next;
    spbe_pkg::block_t state_reg;
    spbe_pkg::block_t state_next;

    // The cell takes a new block when it is empty or its block moves on.
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        state_next = spbe_pkg::linear_layer(spbe_pkg::sbox_layer(up_state ^ stage_key));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            state_reg <= state_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_state = state_reg;

endmodule

`default_nettype wire

>>> rtl/spbe_final_cell.sv
// Last cipher round as a pipeline cell: key add, S-box and final whitening.
`timescale 1ns / 1ps
`default_nettype none

module spbe_final_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire spbe_pkg::block_t up_state,
    input  wire spbe_pkg::block_t stage_key,
    input  wire spbe_pkg::block_t whiten_key,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output spbe_pkg::block_t     dn_state
);

    logic             valid_reg;
    logic             valid_next;
    spbe_pkg::block_t state_reg;
    spbe_pkg::block_t state_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        state_next = spbe_pkg::sbox_layer(up_state ^ stage_key) ^ whiten_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            state_reg <= state_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_state = state_reg;

endmodule

`default_nettype wire

>>> rtl/small_pride_block_encrypt.sv
// Top level of the reduced PRIDE-style block cipher: key registers and the chain of round cells.
//
//   Channel   Direction  Handshake            Payload
//   -------   ---------  -------------------  --------------------------------
//   plain     in         plain_valid/stall    plain_row0 .. plain_row3
//   cipher    out        cipher_valid/stall   cipher_row0 .. cipher_row3
//   cfg       in         cfg_valid/ready      cfg_index, cfg_data (key words)
//
// Each request passes through ROUNDS cells, one round per cell, and every cell
// registers the block before it moves on towards the output.
// A new block is accepted in every cycle in which plain_stall is low; the row of registered
// cells sets that rate and the latency. Reset clears the key words and empties every cell.
// A stall at the output fills empty cells first, so plain_stall rises only once
// every cell holds a block and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module small_pride_block_encrypt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Plaintext channel.
    input  wire logic                       plain_valid,
    output logic                            plain_stall,
    input  wire spbe_pkg::row_t             plain_row0,
    input  wire spbe_pkg::row_t             plain_row1,
    input  wire spbe_pkg::row_t             plain_row2,
    input  wire spbe_pkg::row_t             plain_row3,
    // Ciphertext channel.
    output logic                            cipher_valid,
    input  wire logic                       cipher_stall,
    output spbe_pkg::row_t                  cipher_row0,
    output spbe_pkg::row_t                  cipher_row1,
    output spbe_pkg::row_t                  cipher_row2,
    output spbe_pkg::row_t                  cipher_row3,
    // Key configuration channel.
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire spbe_pkg::cfg_idx_t         cfg_index,
    input  wire spbe_pkg::row_t             cfg_data
);

    localparam int LAST = spbe_pkg::ROUNDS - 1;

    spbe_pkg::block_t key_reg;
    spbe_pkg::block_t key_next;

    // Handshake and data between the cells; entry g feeds cell g.
    logic             link_valid [spbe_pkg::ROUNDS+1];
    logic             link_ready [spbe_pkg::ROUNDS+1];
    spbe_pkg::block_t link_state [spbe_pkg::ROUNDS+1];

    // Key words are written one at a time; the port never pushes back.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spbe_pkg::KEY_ROW0_IDX: key_next[0] = cfg_data;
                spbe_pkg::KEY_ROW1_IDX: key_next[1] = cfg_data;
                spbe_pkg::KEY_ROW2_IDX: key_next[2] = cfg_data;
                spbe_pkg::KEY_ROW3_IDX: key_next[3] = cfg_data;
                default:                key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // The plaintext request enters the first cell.
    assign link_valid[0] = plain_valid;
    assign link_state[0] = {plain_row3, plain_row2, plain_row1, plain_row0};
    assign plain_stall   = !link_ready[0];

    // Full rounds: each cell adds its round key, which is the key XOR a constant row.
    for (genvar g = 0; g < LAST; g++)
    begin : g_round
        spbe_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (link_valid[g]),
            .up_ready  (link_ready[g]),
            .up_state  (link_state[g]),
            .stage_key (key_reg ^ spbe_pkg::round_const(spbe_pkg::RC_IDX_W'(g))),
            .dn_valid  (link_valid[g+1]),
            .dn_ready  (link_ready[g+1]),
            .dn_state  (link_state[g+1])
        );
    end

    // The last cell also holds the result that is offered on the output.
    spbe_final_cell u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (link_valid[LAST]),
        .up_ready   (link_ready[LAST]),
        .up_state   (link_state[LAST]),
        .stage_key  (key_reg ^ spbe_pkg::round_const(spbe_pkg::RC_IDX_W'(LAST))),
        .whiten_key (key_reg ^ spbe_pkg::round_const(spbe_pkg::RC_IDX_W'(spbe_pkg::ROUNDS))),
        .dn_valid   (link_valid[spbe_pkg::ROUNDS]),
        .dn_ready   (link_ready[spbe_pkg::ROUNDS]),
        .dn_state   (link_state[spbe_pkg::ROUNDS])
    );

    assign link_ready[spbe_pkg::ROUNDS] = !cipher_stall;
    assign cipher_valid = link_valid[spbe_pkg::ROUNDS];
    assign cipher_row0  = link_state[spbe_pkg::ROUNDS][0];
    assign cipher_row1  = link_state[spbe_pkg::ROUNDS][1];
    assign cipher_row2  = link_state[spbe_pkg::ROUNDS][2];
    assign cipher_row3  = link_state[spbe_pkg::ROUNDS][3];

    // The input is held off only while the output itself is blocked.
    a_stall_only_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        plain_stall |-> (cipher_valid && cipher_stall))
        else $error("plaintext stalled while the output is free");

    // An accepted request always lands in the first cell.
    a_accept_fills_first_cell: assert property (
        @(posedge clk) disable iff (!rst_n)
        (plain_valid && !plain_stall) |=> link_valid[1])
        else $error("accepted request lost at the first cell");

    // A key write to row 0 reaches that key word on the next cycle.
    a_key_row0_written: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == spbe_pkg::KEY_ROW0_IDX)
            |=> key_reg[0] == $past(cfg_data))
        else $error("key word for row 0 not updated");

    // A stalled result keeps its value until it is taken.
    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cipher_valid && cipher_stall) |=> (cipher_valid && $stable(link_state[spbe_pkg::ROUNDS])))
        else $error("stalled result changed");

endmodule

`default_nettype wire

>>> tb/sv/small_pride_block_encrypt_test.sv
// Self-checking testbench for the reduced-round PRIDE-style block encryption core.
`timescale 1ns / 1ps

module small_pride_block_encrypt_test;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 7;
    // After the last ciphertext has left the core, the settling pause gives the
    // pipeline time to be truly empty.
    localparam int SETTLE_CYCLES   = spbe_pkg::ROUNDS + 4;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 130;
    // Longest quiet spell of a correct run is a sender gap or a receiver stall
    // run plus the pipeline latency and the settling pause; this is far above it.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_DIRECTED    = 16;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               plain_valid  = 1'b0;
    logic               plain_stall;
    spbe_pkg::row_t     plain_row0   = '0;
    spbe_pkg::row_t     plain_row1   = '0;
    spbe_pkg::row_t     plain_row2   = '0;
    spbe_pkg::row_t     plain_row3   = '0;
    logic               cipher_valid;
    logic               cipher_stall = 1'b0;
    spbe_pkg::row_t     cipher_row0;
    spbe_pkg::row_t     cipher_row1;
    spbe_pkg::row_t     cipher_row2;
    spbe_pkg::row_t     cipher_row3;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    spbe_pkg::cfg_idx_t cfg_index    = spbe_pkg::KEY_ROW0_IDX;
    spbe_pkg::row_t     cfg_data     = '0;

    // Our own copy of the key registers, updated on every accepted key write.
    spbe_pkg::block_t   key_shadow   = '0;
    // Ciphertexts still owed by the core, oldest first.
    spbe_pkg::block_t   pending_cipher [$];

    int       mismatch_count  = 0;
    int       ciphers_checked = 0;
    int       blocks_sent     = 0;
    int       key_settings    = 1;
    int       idle_cycles     = 0;
    int       burst_left      = 1;
    int       stall_run       = 0;
    int       stall_mode      = 0;

    spbe_pkg::cfg_idx_t key_reg_order [4] = '{spbe_pkg::KEY_ROW0_IDX, spbe_pkg::KEY_ROW1_IDX,
                                              spbe_pkg::KEY_ROW2_IDX, spbe_pkg::KEY_ROW3_IDX};

    // Directed blocks, written as {row3, row2, row1, row0}. A ciphertext after
    // nine rounds cannot be read off by eye, so every row is checked against
    // the predictor rather than against a typed-in answer.
    spbe_pkg::block_t   directed_tab [NUM_DIRECTED] = '{
        64'h0000_0000_0000_0000,    // all zero
        64'hffff_ffff_ffff_ffff,    // all one
        64'hff00_f0f0_cccc_aaaa,    // every S-box input value appears in one column
        64'h00ff_0f0f_3333_5555,    // the same columns inverted
        64'h0000_0000_0000_ffff,    // one row set at a time
        64'h0000_0000_ffff_0000,
        64'h0000_ffff_0000_0000,
        64'hffff_0000_0000_0000,
        64'h0001_0001_0001_0001,    // lowest column only
        64'h8000_8000_8000_8000,    // highest column only
        64'haaaa_5555_aaaa_5555,
        64'h00ff_ff00_00ff_ff00,    // byte halves of the middle rows at their extremes
        64'h8001_8001_0180_0180,    // bits at the edges of each byte half
        64'h0123_4567_89ab_cdef,
        64'h0000_0000_0000_0000,    // a repeat of the first block
        64'h7fff_7fff_7fff_7fff
    };

    small_pride_block_encrypt DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .plain_valid  (plain_valid),
        .plain_stall  (plain_stall),
        .plain_row0   (plain_row0),
        .plain_row1   (plain_row1),
        .plain_row2   (plain_row2),
        .plain_row3   (plain_row3),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_row0  (cipher_row0),
        .cipher_row1  (cipher_row1),
        .cipher_row2  (cipher_row2),
        .cipher_row3  (cipher_row3),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    function automatic spbe_pkg::row_t rotl16(input spbe_pkg::row_t x, input int k);
        return (x << k) | (x >> (16 - k));
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int k);
        return (x << k) | (x >> (8 - k));
    endfunction

    // Fixed tweak for round r; the first row and everything from nine up are zero.
    function automatic spbe_pkg::block_t round_tweak(input int r);
        spbe_pkg::block_t t;
        t = '0;
        case (r)
            1: begin t[0] = 16'h7344; t[1] = 16'h0370; t[2] = 16'h8a2e; t[3] = 16'h1319; end
            2: begin t[0] = 16'h31d0; t[1] = 16'h299f; t[2] = 16'h3822; t[3] = 16'ha409; end
            3: begin t[0] = 16'h6c89; t[1] = 16'hec4e; t[2] = 16'hfa98; t[3] = 16'h082e; end
            4: begin t[0] = 16'h1377; t[1] = 16'h38d0; t[2] = 16'h21e6; t[3] = 16'h4528; end
            5: begin t[0] = 16'h0c6c; t[1] = 16'h34e9; t[2] = 16'h66cf; t[3] = 16'hbe54; end
            6: begin t[0] = 16'h5cb1; t[1] = 16'hfd95; t[2] = 16'h4f78; t[3] = 16'h7ef8; end
            7: begin t[0] = 16'h43aa; t[1] = 16'hf1ac; t[2] = 16'h0851; t[3] = 16'h8584; end
            8: begin t[0] = 16'h3c54; t[1] = 16'h2532; t[2] = 16'hd32f; t[3] = 16'hc882; end
            default: t = '0;
        endcase
        return t;
    endfunction

    // Bitsliced S-box: column k of the four rows is one 4-bit substitution.
    function automatic spbe_pkg::block_t substitute_columns(input spbe_pkg::block_t s);
        spbe_pkg::block_t o;
        o[0] = s[2] ^ (s[0] & s[1]);
        o[1] = s[3] ^ (s[1] & s[2]);
        o[2] = s[0] ^ (o[0] & o[1]);
        o[3] = s[1] ^ (o[1] & o[2]);
        return o;
    endfunction

    function automatic spbe_pkg::block_t diffuse_rows(input spbe_pkg::block_t s);
        spbe_pkg::block_t o;
        logic [7:0]       h1;
        logic [7:0]       l1;
        logic [7:0]       h2;
        logic [7:0]       l2;
        h1 = s[1][15:8];
        l1 = s[1][7:0];
        h2 = s[2][15:8];
        l2 = s[2][7:0];
        o[0] = rotl16(s[0], 4) ^ rotl16(s[0], 8) ^ rotl16(s[0], 12);
        o[1] = {h1 ^ rotl8(h1, 1) ^ rotl8(l1, 3), h1 ^ rotl8(l1, 3) ^ rotl8(l1, 4)};
        o[2] = {rotl8(h2, 4) ^ rotl8(h2, 5) ^ rotl8(l2, 7), rotl8(h2, 4) ^ l2 ^ rotl8(l2, 7)};
        o[3] = s[3] ^ rotl16(s[3], 4) ^ rotl16(s[3], 12);
        return o;
    endfunction

    // Full encryption of one block under the given master key.
    function automatic spbe_pkg::block_t encrypt_block(input spbe_pkg::block_t plain,
                                                       input spbe_pkg::block_t key);
        spbe_pkg::block_t s;
        s = plain;
        for (int r = 0; r < spbe_pkg::ROUNDS - 1; r++)
        begin
            s = diffuse_rows(substitute_columns(s ^ key ^ round_tweak(r)));
        end
        s = substitute_columns(s ^ key ^ round_tweak(spbe_pkg::ROUNDS - 1));
        return s ^ key ^ round_tweak(spbe_pkg::ROUNDS);
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: the output stall follows patterns of its own, each held for a
    // random run of cycles, from free flow up to long stretches of stalling.
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(8, 60);
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       cipher_stall <= 1'b0;
            1:       cipher_stall <= ($urandom_range(0, 3) == 0);
            2:       cipher_stall <= ($urandom_range(0, 1) == 0);
            default: cipher_stall <= (stall_run[2:0] != 3'd0);
        endcase
    end

    // ---------------------------------------------------------------------
    // Scoreboard: predicts on every accepted request, compares every accepted
    // ciphertext with the oldest prediction, and tracks key writes.
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        spbe_pkg::block_t got;
        spbe_pkg::block_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_shadow[cfg_index] = cfg_data;
            end
            if (plain_valid && !plain_stall)
            begin
                pending_cipher.push_back(encrypt_block(
                    {plain_row3, plain_row2, plain_row1, plain_row0}, key_shadow));
            end
            if (cipher_valid && !cipher_stall)
            begin
                got = {cipher_row3, cipher_row2, cipher_row1, cipher_row0};
                if (pending_cipher.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: ciphertext %h arrived with no request outstanding",
                             $time, got);
                end
                else
                begin
                    want = pending_cipher.pop_front();
                    ciphers_checked++;
                    for (int j = 0; j < spbe_pkg::NUM_ROWS; j++)
                    begin
                        if (got[j] !== want[j])
                        begin
                            mismatch_count++;
                            $display("%0t: cipher_row%0d expected %h actual %h",
                                     $time, j, want[j], got[j]);
                        end
                    end
                end
            end
        end
    end

    // The watchdog counts cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (plain_valid && !plain_stall) || (cipher_valid && !cipher_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d ciphertexts outstanding",
                     idle_cycles, pending_cipher.size());
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Sender tasks
    // ---------------------------------------------------------------------

    // Presents one request and holds it until taken. Requests go out in bursts
    // of random length; at the end of a burst the sender may drop valid for a
    // random gap. Valid stays high across back-to-back requests.
    task automatic issue_block(input spbe_pkg::block_t blk);
        int gap;
        plain_valid <= 1'b1;
        {plain_row3, plain_row2, plain_row1, plain_row0} <= blk;
        do @(posedge clk); while (plain_stall);
        blocks_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                plain_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Holds the sender back until every owed ciphertext has come out, then
    // lets the pipeline settle so that the core is idle.
    task automatic drain_pipeline();
        plain_valid <= 1'b0;
        while (pending_cipher.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four key words, keeping cfg_valid high between them.
    task automatic load_key(input spbe_pkg::block_t key);
        for (int j = 0; j < spbe_pkg::NUM_ROWS; j++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= key_reg_order[j];
            cfg_data  <= key[key_reg_order[j]];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random row, biased now and then towards the extremes and single bits.
    function automatic spbe_pkg::row_t pick_row();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return spbe_pkg::row_t'(1) << $urandom_range(0, 15);
            default: return spbe_pkg::row_t'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        spbe_pkg::block_t key;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks under the key left by reset, which is all zero.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            issue_block(directed_tab[i]);
        end

        // Random blocks under a series of keys. Each change of key waits for
        // the core to go idle first, which also makes the sender wait for
        // every outstanding ciphertext.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_pipeline();
            case (p)
                0:       key = '1;
                2:       key = 64'haaaa_5555_aaaa_5555;
                4:       key = 64'hffff_0000_ffff_0000;
                5:       key = '0;
                default: key = {$urandom, $urandom};
            endcase
            load_key(key);
            key_settings++;
            repeat (ITEMS_PER_PHASE)
            begin
                issue_block({pick_row(), pick_row(), pick_row(), pick_row()});
            end
        end

        drain_pipeline();
        if (pending_cipher.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d ciphertexts never arrived", $time, pending_cipher.size());
        end

        $display("Summary: %0d blocks encrypted under %0d key settings,", blocks_sent,
                 key_settings);
        $display("         %0d ciphertexts compared, %0d mismatches.", ciphers_checked,
                 mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
